// ----- rtl/ffba_pkg.sv -----
// ffba_pkg: widths, command codes, datapath operation codes and the
// controller/datapath link structures of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

    localparam int CMD_W   = 2;
    localparam int REQ_W   = 12;
    localparam int OFF_W   = 12;
    localparam int PSZ_W   = 13;
    localparam int WORD_W  = 16;   // header fields: two bytes each
    localparam int SUM_W   = 18;   // address sums before the page bound check
    localparam int RESERVED_HEADERS = 3;

    localparam int DEF_PAGE_BYTES         = 4096;
    localparam int DEF_BLOCK_HEADER_BYTES = 4;
    localparam int DEF_PAGE_HEADER_BYTES  = 6;

    localparam logic [PSZ_W-1:0] PAGE_SIZE_RESET = PSZ_W'(4096);

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REINIT = 2'd2;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_LATCH,
        OP_START_ALLOC,
        OP_START_FREE,
        OP_START_SCAN,
        OP_RD_CUR_SIZE,
        OP_RD_CUR_NEXT,
        OP_RD_CUR_NEXT_STEP,
        OP_RD_NXT_SIZE,
        OP_RD_NXT_NEXT,
        OP_RD_NXT_NEXT_STEP,
        OP_RD_PREV_SIZE,
        OP_LOAD_S,
        OP_LOAD_S_RD_NEXT,
        OP_LOAD_TMP,
        OP_LOAD_PZ,
        OP_ADVANCE,
        OP_SCAN_ADV,
        OP_ADD_S,
        OP_ADD_PZ,
        OP_SET_FHEAD_NB,
        OP_SET_FHEAD_TMP,
        OP_SET_FHEAD_CUR,
        OP_SET_UHEAD_TMP,
        OP_WR_NB_NEXT,
        OP_WR_NB_SIZE,
        OP_WR_PREV_NEXT_NB,
        OP_WR_PREV_NEXT_TMP,
        OP_WR_PREV_NEXT_CUR,
        OP_WR_PREV_SIZE_PZ,
        OP_WR_CUR_SIZE_REQ,
        OP_WR_CUR_SIZE_S,
        OP_WR_CUR_NEXT_UHEAD,
        OP_WR_CUR_NEXT_NXT,
        OP_WR_CUR_NEXT_TMP,
        OP_WR_FIRST_SIZE,
        OP_WR_FIRST_NEXT,
        OP_REINIT_START,
        OP_REINIT_FAIL,
        OP_REINIT_DONE,
        OP_ALLOC_DONE,
        OP_FREE_DONE,
        OP_FAIL,
        OP_PUSH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic hi;     // byte lane of a header write (high byte when set)
        logic take;   // input channel ready
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic ready;
        logic cur_zero;
        logic prev_zero;
        logic nxt_zero;
        logic walk_over;
        logic fits;
        logic split;
        logic is_target;
        logic nxt_before;
        logic merge_next;
        logic merge_prev;
        logic ps_small;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/ffba_if.sv -----
// ffba_cmd_if / ffba_rsp_if: valid/ready channels of the allocator.
// Depends on ffba_pkg.
interface ffba_cmd_if;
    import ffba_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] block_offset;

    modport source (output valid, command, request_size, block_offset, input ready);
    modport sink   (input valid, command, request_size, block_offset, output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] data_offset;
    logic             status;

    modport source (output valid, data_offset, status, input ready);
    modport sink   (input valid, data_offset, status, output ready);
endinterface

// ----- rtl/ffba_datapath.sv -----
// ffba_datapath: page byte store, list heads, walk registers and result
// register of the allocator; executes one operation code per cycle.
// Depends on ffba_pkg.
module ffba_datapath #(
    parameter int PAGE_BYTES         = ffba_pkg::DEF_PAGE_BYTES,
    parameter int BLOCK_HEADER_BYTES = ffba_pkg::DEF_BLOCK_HEADER_BYTES,
    parameter int PAGE_HEADER_BYTES  = ffba_pkg::DEF_PAGE_HEADER_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ffba_pkg::ctl_t             ctl,
    output ffba_pkg::stat_t            stat,
    input  logic                       in_valid,
    input  logic [ffba_pkg::CMD_W-1:0] in_command,
    input  logic [ffba_pkg::REQ_W-1:0] in_request_size,
    input  logic [ffba_pkg::OFF_W-1:0] in_block_offset,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ffba_pkg::OFF_W-1:0] out_data_offset,
    output logic                       out_status,
    input  logic                       page_size_we,
    input  logic [ffba_pkg::PSZ_W-1:0] page_size_wdata
);
    import ffba_pkg::*;

    localparam int AW         = $clog2(PAGE_BYTES);
    localparam int WALK_LIMIT = PAGE_BYTES / BLOCK_HEADER_BYTES + 1;
    localparam int STW        = $clog2(WALK_LIMIT + 1);

    localparam logic [SUM_W-1:0] HDR   = SUM_W'(BLOCK_HEADER_BYTES);
    localparam logic [SUM_W-1:0] PB    = SUM_W'(PAGE_BYTES);
    localparam logic [SUM_W-1:0] FIRST = SUM_W'(PAGE_HEADER_BYTES + 2 * BLOCK_HEADER_BYTES);
    localparam logic [SUM_W-1:0] NEED  =
        SUM_W'(PAGE_HEADER_BYTES + RESERVED_HEADERS * BLOCK_HEADER_BYTES);
    localparam logic [SUM_W-1:0] TWO   = SUM_W'(2);
    localparam logic [STW-1:0]   STEP_MAX = STW'(WALK_LIMIT);

    logic [7:0] mem [PAGE_BYTES];

    logic [7:0]        lo_q, hi_q;
    logic              oob_q;
    logic [WORD_W-1:0] rd_val;

    logic [WORD_W-1:0] cur_reg, prev_reg, nxt_reg, tmp_reg, s_reg, pz_reg;
    logic [SUM_W-1:0]  nb_reg, ps_reg;
    logic [STW-1:0]    steps_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [OFF_W-1:0]  blk_reg;
    logic [OFF_W-1:0]  res_off_reg, out_off_reg;
    logic              res_st_reg, out_st_reg, out_valid_reg;
    logic [WORD_W-1:0] fhead_reg, uhead_reg;
    logic              ready_reg;
    logic [PSZ_W-1:0]  page_size_reg;

    logic              rd_en, wr_en, oob;
    logic [SUM_W-1:0]  acc_addr, hi_addr, wr_addr, ps_sat;
    logic [WORD_W-1:0] wr_val;
    logic [7:0]        wr_byte;
    logic [SUM_W-1:0]  cur_x, prev_x, nxt_x;

    assign cur_x  = SUM_W'(cur_reg);
    assign prev_x = SUM_W'(prev_reg);
    assign nxt_x  = SUM_W'(nxt_reg);
    assign rd_val = oob_q ? '0 : {hi_q, lo_q};

    // address and data of this cycle's header access
    always_comb
    begin
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        acc_addr = '0;
        wr_val   = '0;
        case (ctl.op)
            OP_RD_CUR_SIZE:      begin rd_en = 1'b1; acc_addr = cur_x; end
            OP_LOAD_S_RD_NEXT,
            OP_RD_CUR_NEXT,
            OP_RD_CUR_NEXT_STEP: begin rd_en = 1'b1; acc_addr = cur_x + TWO; end
            OP_RD_NXT_SIZE:      begin rd_en = 1'b1; acc_addr = nxt_x; end
            OP_RD_NXT_NEXT,
            OP_RD_NXT_NEXT_STEP: begin rd_en = 1'b1; acc_addr = nxt_x + TWO; end
            OP_RD_PREV_SIZE:     begin rd_en = 1'b1; acc_addr = prev_x; end
            OP_WR_NB_NEXT:
            begin
                wr_en = 1'b1; acc_addr = nb_reg + TWO; wr_val = tmp_reg;
            end
            OP_WR_NB_SIZE:
            begin
                wr_en = 1'b1; acc_addr = nb_reg;
                wr_val = WORD_W'(SUM_W'(s_reg) - (SUM_W'(req_reg) + HDR));
            end
            OP_WR_PREV_NEXT_NB:
            begin
                wr_en = 1'b1; acc_addr = prev_x + TWO; wr_val = nb_reg[WORD_W-1:0];
            end
            OP_WR_PREV_NEXT_TMP:
            begin
                wr_en = 1'b1; acc_addr = prev_x + TWO; wr_val = tmp_reg;
            end
            OP_WR_PREV_NEXT_CUR:
            begin
                wr_en = 1'b1; acc_addr = prev_x + TWO; wr_val = cur_reg;
            end
            OP_WR_PREV_SIZE_PZ:
            begin
                wr_en = 1'b1; acc_addr = prev_x; wr_val = pz_reg;
            end
            OP_WR_CUR_SIZE_REQ:
            begin
                wr_en = 1'b1; acc_addr = cur_x; wr_val = WORD_W'(req_reg);
            end
            OP_WR_CUR_SIZE_S:
            begin
                wr_en = 1'b1; acc_addr = cur_x; wr_val = s_reg;
            end
            OP_WR_CUR_NEXT_UHEAD:
            begin
                wr_en = 1'b1; acc_addr = cur_x + TWO; wr_val = uhead_reg;
            end
            OP_WR_CUR_NEXT_NXT:
            begin
                wr_en = 1'b1; acc_addr = cur_x + TWO; wr_val = nxt_reg;
            end
            OP_WR_CUR_NEXT_TMP:
            begin
                wr_en = 1'b1; acc_addr = cur_x + TWO; wr_val = tmp_reg;
            end
            OP_WR_FIRST_SIZE:
            begin
                wr_en = 1'b1; acc_addr = FIRST; wr_val = WORD_W'(ps_reg - NEED);
            end
            OP_WR_FIRST_NEXT:
            begin
                wr_en = 1'b1; acc_addr = FIRST + TWO; wr_val = '0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // headers reaching past the page end read as zero and are not written
    assign hi_addr = acc_addr + SUM_W'(1);
    assign oob     = (hi_addr >= PB);
    assign wr_addr = ctl.hi ? hi_addr : acc_addr;
    assign wr_byte = ctl.hi ? wr_val[15:8] : wr_val[7:0];
    assign ps_sat  = (SUM_W'(page_size_reg) > PB) ? PB : SUM_W'(page_size_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en && !oob)
        begin
            mem[wr_addr[AW-1:0]] <= wr_byte;
        end
        if (rd_en)
        begin
            lo_q  <= mem[acc_addr[AW-1:0]];
            hi_q  <= mem[hi_addr[AW-1:0]];
            oob_q <= oob;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LATCH:
            begin
                if (in_valid)
                begin
                    cmd_reg <= in_command;
                    req_reg <= in_request_size;
                    blk_reg <= in_block_offset;
                end
            end
            OP_START_ALLOC:
            begin
                cur_reg <= fhead_reg; prev_reg <= '0; steps_reg <= '0;
            end
            OP_START_FREE:
            begin
                cur_reg <= uhead_reg; prev_reg <= '0; steps_reg <= '0;
            end
            OP_START_SCAN:
            begin
                nxt_reg <= fhead_reg; prev_reg <= '0; steps_reg <= '0;
            end
            OP_RD_CUR_SIZE,
            OP_RD_CUR_NEXT_STEP,
            OP_RD_NXT_NEXT_STEP: steps_reg <= steps_reg + STW'(1);
            OP_LOAD_S,
            OP_LOAD_S_RD_NEXT:   s_reg <= rd_val;
            OP_LOAD_PZ:          pz_reg <= rd_val;
            OP_LOAD_TMP:
            begin
                tmp_reg <= rd_val;
                nb_reg  <= cur_x + HDR + SUM_W'(req_reg);
            end
            OP_ADVANCE:
            begin
                prev_reg <= cur_reg; cur_reg <= rd_val;
            end
            OP_SCAN_ADV:
            begin
                prev_reg <= nxt_reg; nxt_reg <= rd_val;
            end
            OP_ADD_S:  s_reg  <= WORD_W'(SUM_W'(s_reg) + SUM_W'(rd_val) + HDR);
            OP_ADD_PZ: pz_reg <= WORD_W'(SUM_W'(pz_reg) + SUM_W'(s_reg) + HDR);
            OP_REINIT_START: ps_reg <= ps_sat;
            OP_FAIL,
            OP_REINIT_FAIL:
            begin
                res_off_reg <= '0; res_st_reg <= 1'b1;
            end
            OP_ALLOC_DONE:
            begin
                res_off_reg <= OFF_W'(cur_x + HDR); res_st_reg <= 1'b0;
            end
            OP_FREE_DONE,
            OP_REINIT_DONE:
            begin
                res_off_reg <= '0; res_st_reg <= 1'b0;
            end
            OP_PUSH:
            begin
                out_off_reg <= res_off_reg; out_st_reg <= res_st_reg;
            end
            default:
            begin
                steps_reg <= steps_reg;
            end
        endcase
    end

    // list heads, page state, configuration and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fhead_reg     <= '0;
            uhead_reg     <= '0;
            ready_reg     <= 1'b0;
            page_size_reg <= PAGE_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (page_size_we)
            begin
                page_size_reg <= page_size_wdata;
            end
            if (ctl.op == OP_PUSH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (ctl.op)
                OP_SET_FHEAD_NB:  fhead_reg <= nb_reg[WORD_W-1:0];
                OP_SET_FHEAD_TMP: fhead_reg <= tmp_reg;
                OP_SET_FHEAD_CUR: fhead_reg <= cur_reg;
                OP_SET_UHEAD_TMP: uhead_reg <= tmp_reg;
                OP_ALLOC_DONE:    uhead_reg <= cur_reg;
                OP_REINIT_START:
                begin
                    fhead_reg <= '0; uhead_reg <= '0;
                end
                OP_REINIT_FAIL:   ready_reg <= 1'b0;
                OP_REINIT_DONE:
                begin
                    fhead_reg <= FIRST[WORD_W-1:0]; ready_reg <= 1'b1;
                end
                default:
                begin
                    ready_reg <= ready_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.ready      = ready_reg;
        stat.cur_zero   = (cur_reg == '0);
        stat.prev_zero  = (prev_reg == '0);
        stat.nxt_zero   = (nxt_reg == '0);
        stat.walk_over  = (steps_reg == STEP_MAX);
        stat.fits       = (s_reg >= WORD_W'(req_reg));
        stat.split      = (SUM_W'(s_reg) > SUM_W'(req_reg) + HDR);
        stat.is_target  = (cur_x + HDR == SUM_W'(blk_reg));
        stat.nxt_before = (nxt_reg < cur_reg);
        stat.merge_next = (cur_x + HDR + SUM_W'(s_reg) == nxt_x);
        stat.merge_prev = (prev_x + HDR + SUM_W'(pz_reg) == cur_x);
        stat.ps_small   = (ps_reg < NEED);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_data_offset = out_off_reg;
    assign out_status      = out_st_reg;

endmodule

// ----- rtl/ffba_ctrl.sv -----
// ffba_ctrl: sequencing state machine of the allocator; issues one datapath
// operation per cycle from the datapath status. Depends on ffba_pkg.
module ffba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ffba_pkg::stat_t stat,
    output ffba_pkg::ctl_t  ctl
);
    import ffba_pkg::*;

    typedef enum logic [5:0] {
        S_BOOT, S_IDLE, S_DISPATCH, S_RESULT,
        S_A_CHECK, S_A_SIZE, S_A_NEXT, S_A_FIT, S_A_NBS, S_A_LINKNB, S_A_CURSZ,
        S_A_PUSHU, S_A_DONE,
        S_F_CHECK, S_F_ADV, S_F_UNLINK, S_F_UNLINK2, S_F_SCAN0, S_F_SCAN, S_F_SCANADV,
        S_F_LINK1, S_F_LINK2,
        S_F_MN0, S_F_MN1, S_F_MN2, S_F_MN3, S_F_MN4, S_F_MN5, S_F_MN6, S_F_MN7,
        S_F_MP0, S_F_MP1, S_F_MP2, S_F_MP3, S_F_MP4, S_F_MP5, S_F_MP6, S_F_MP7, S_F_MP8,
        S_F_DONE,
        S_R_CHECK, S_R_NEXT, S_R_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   boot_reg, boot_next;
    op_t    op;

    always_comb
    begin
        state_next = state_reg;
        phase_next = 1'b0;
        boot_next  = boot_reg;
        op         = OP_NONE;
        // header writes go low byte first, then high byte
        case (state_reg)
            S_BOOT:
            begin
                op = OP_REINIT_START; state_next = S_R_CHECK;
            end
            S_IDLE:
            begin
                op = OP_LATCH;
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.cmd == CMD_REINIT)
                begin
                    op = OP_REINIT_START; state_next = S_R_CHECK;
                end
                else if (stat.cmd == CMD_ALLOC && stat.ready)
                begin
                    op = OP_START_ALLOC; state_next = S_A_CHECK;
                end
                else if (stat.cmd == CMD_FREE && stat.ready)
                begin
                    op = OP_START_FREE; state_next = S_F_CHECK;
                end
                else
                begin
                    op = OP_FAIL; state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    op = OP_PUSH; state_next = S_IDLE;
                end
            end

            S_A_CHECK:
            begin
                if (stat.cur_zero || stat.walk_over)
                begin
                    op = OP_FAIL; state_next = S_RESULT;
                end
                else
                begin
                    op = OP_RD_CUR_SIZE; state_next = S_A_SIZE;
                end
            end
            S_A_SIZE:
            begin
                op = OP_LOAD_S_RD_NEXT; state_next = S_A_NEXT;
            end
            S_A_NEXT:
            begin
                if (stat.fits)
                begin
                    op = OP_LOAD_TMP; state_next = S_A_FIT;
                end
                else
                begin
                    op = OP_ADVANCE; state_next = S_A_CHECK;
                end
            end
            S_A_FIT:
            begin
                if (stat.split)
                begin
                    op = OP_WR_NB_NEXT; phase_next = !phase_reg;
                    if (phase_reg) state_next = S_A_NBS;
                end
                else if (stat.prev_zero)
                begin
                    op = OP_SET_FHEAD_TMP; state_next = S_A_PUSHU;
                end
                else
                begin
                    op = OP_WR_PREV_NEXT_TMP; phase_next = !phase_reg;
                    if (phase_reg) state_next = S_A_PUSHU;
                end
            end
            S_A_NBS:
            begin
                op = OP_WR_NB_SIZE; phase_next = !phase_reg;
                if (phase_reg) state_next = S_A_LINKNB;
            end
            S_A_LINKNB:
            begin
                if (stat.prev_zero)
                begin
                    op = OP_SET_FHEAD_NB; state_next = S_A_CURSZ;
                end
                else
                begin
                    op = OP_WR_PREV_NEXT_NB; phase_next = !phase_reg;
                    if (phase_reg) state_next = S_A_CURSZ;
                end
            end
            S_A_CURSZ:
            begin
                op = OP_WR_CUR_SIZE_REQ; phase_next = !phase_reg;
                if (phase_reg) state_next = S_A_PUSHU;
            end
            S_A_PUSHU:
            begin
                op = OP_WR_CUR_NEXT_UHEAD; phase_next = !phase_reg;
                if (phase_reg) state_next = S_A_DONE;
            end
            S_A_DONE:
            begin
                op = OP_ALLOC_DONE; state_next = S_RESULT;
            end

            S_F_CHECK:
            begin
                if (stat.cur_zero)
                begin
                    op = OP_FAIL; state_next = S_RESULT;
                end
                else if (stat.is_target)
                begin
                    op = OP_RD_CUR_NEXT; state_next = S_F_UNLINK;
                end
                else if (stat.walk_over)
                begin
                    op = OP_FAIL; state_next = S_RESULT;
                end
                else
                begin
                    op = OP_RD_CUR_NEXT_STEP; state_next = S_F_ADV;
                end
            end
            S_F_ADV:
            begin
                op = OP_ADVANCE; state_next = S_F_CHECK;
            end
            S_F_UNLINK:
            begin
                op = OP_LOAD_TMP; state_next = S_F_UNLINK2;
            end
            S_F_UNLINK2:
            begin
                if (stat.prev_zero)
                begin
                    op = OP_SET_UHEAD_TMP; state_next = S_F_SCAN0;
                end
                else
                begin
                    op = OP_WR_PREV_NEXT_TMP; phase_next = !phase_reg;
                    if (phase_reg) state_next = S_F_SCAN0;
                end
            end
            S_F_SCAN0:
            begin
                op = OP_START_SCAN; state_next = S_F_SCAN;
            end
            S_F_SCAN:
            begin
                // stop at the first free block above the one released
                if (stat.nxt_zero || !stat.nxt_before)
                begin
                    state_next = S_F_LINK1;
                end
                else if (stat.walk_over)
                begin
                    op = OP_FAIL; state_next = S_RESULT;
                end
                else
                begin
                    op = OP_RD_NXT_NEXT_STEP; state_next = S_F_SCANADV;
                end
            end
            S_F_SCANADV:
            begin
                op = OP_SCAN_ADV; state_next = S_F_SCAN;
            end
            S_F_LINK1:
            begin
                op = OP_WR_CUR_NEXT_NXT; phase_next = !phase_reg;
                if (phase_reg) state_next = S_F_LINK2;
            end
            S_F_LINK2:
            begin
                if (stat.prev_zero)
                begin
                    op = OP_SET_FHEAD_CUR; state_next = S_F_MN0;
                end
                else
                begin
                    op = OP_WR_PREV_NEXT_CUR; phase_next = !phase_reg;
                    if (phase_reg) state_next = S_F_MN0;
                end
            end
            S_F_MN0:
            begin
                if (stat.nxt_zero)
                begin
                    state_next = S_F_MP0;
                end
                else
                begin
                    op = OP_RD_CUR_SIZE; state_next = S_F_MN1;
                end
            end
            S_F_MN1:
            begin
                op = OP_LOAD_S; state_next = S_F_MN2;
            end
            S_F_MN2:
            begin
                if (stat.merge_next)
                begin
                    op = OP_RD_NXT_SIZE; state_next = S_F_MN3;
                end
                else
                begin
                    state_next = S_F_MP0;
                end
            end
            S_F_MN3:
            begin
                op = OP_ADD_S; state_next = S_F_MN4;
            end
            S_F_MN4:
            begin
                op = OP_WR_CUR_SIZE_S; phase_next = !phase_reg;
                if (phase_reg) state_next = S_F_MN5;
            end
            S_F_MN5:
            begin
                op = OP_RD_NXT_NEXT; state_next = S_F_MN6;
            end
            S_F_MN6:
            begin
                op = OP_LOAD_TMP; state_next = S_F_MN7;
            end
            S_F_MN7:
            begin
                op = OP_WR_CUR_NEXT_TMP; phase_next = !phase_reg;
                if (phase_reg) state_next = S_F_MP0;
            end
            S_F_MP0:
            begin
                if (stat.prev_zero)
                begin
                    state_next = S_F_DONE;
                end
                else
                begin
                    op = OP_RD_PREV_SIZE; state_next = S_F_MP1;
                end
            end
            S_F_MP1:
            begin
                op = OP_LOAD_PZ; state_next = S_F_MP2;
            end
            S_F_MP2:
            begin
                op = OP_RD_CUR_SIZE; state_next = S_F_MP3;
            end
            S_F_MP3:
            begin
                op = OP_LOAD_S; state_next = S_F_MP4;
            end
            S_F_MP4:
            begin
                if (stat.merge_prev)
                begin
                    op = OP_ADD_PZ; state_next = S_F_MP5;
                end
                else
                begin
                    state_next = S_F_DONE;
                end
            end
            S_F_MP5:
            begin
                op = OP_WR_PREV_SIZE_PZ; phase_next = !phase_reg;
                if (phase_reg) state_next = S_F_MP6;
            end
            S_F_MP6:
            begin
                op = OP_RD_CUR_NEXT; state_next = S_F_MP7;
            end
            S_F_MP7:
            begin
                op = OP_LOAD_TMP; state_next = S_F_MP8;
            end
            S_F_MP8:
            begin
                op = OP_WR_PREV_NEXT_TMP; phase_next = !phase_reg;
                if (phase_reg) state_next = S_F_DONE;
            end
            S_F_DONE:
            begin
                op = OP_FREE_DONE; state_next = S_RESULT;
            end

            S_R_CHECK:
            begin
                if (stat.ps_small)
                begin
                    op = OP_REINIT_FAIL; state_next = S_RESULT;
                end
                else
                begin
                    op = OP_WR_FIRST_SIZE; phase_next = !phase_reg;
                    if (phase_reg) state_next = S_R_NEXT;
                end
            end
            S_R_NEXT:
            begin
                op = OP_WR_FIRST_NEXT; phase_next = !phase_reg;
                if (phase_reg) state_next = S_R_DONE;
            end
            S_R_DONE:
            begin
                // the build after reset gives no result beat
                op = OP_REINIT_DONE;
                state_next = boot_reg ? S_IDLE : S_RESULT;
                boot_next = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            phase_reg <= 1'b0;
            boot_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            boot_reg  <= boot_next;
        end
    end

    always_comb
    begin
        ctl.op   = op;
        ctl.hi   = phase_reg;
        ctl.take = (state_reg == S_IDLE);
    end

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// First-fit block allocator over a byte page with address-ordered free list,
// used list and coalescing on free. Each command takes one input beat and gives
// one result beat. The time per command, from the accepting cycle to the result
// beat being loaded, is set by the walk over linked headers in the single-ported
// byte store (one header field read or one byte written per cycle): allocate walks
// the free blocks passed over; free walks the used blocks ahead of the released
// one and the free blocks below it. After reset the page is built before the
// first command beat is taken. A result waiting on the output does not stop the
// next command being taken.
// Depends on ffba_pkg, ffba_if, ffba_ctrl and ffba_datapath.
module first_fit_block_allocator #(
    parameter int PAGE_BYTES         = ffba_pkg::DEF_PAGE_BYTES,
    parameter int BLOCK_HEADER_BYTES = ffba_pkg::DEF_BLOCK_HEADER_BYTES,
    parameter int PAGE_HEADER_BYTES  = ffba_pkg::DEF_PAGE_HEADER_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ffba_cmd_if.sink                   cmd_ch,
    ffba_rsp_if.source                 rsp_ch,
    input  logic                       page_size_we,
    input  logic [ffba_pkg::PSZ_W-1:0] page_size_wdata
);
    import ffba_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .stat     (stat),
        .ctl      (ctl)
    );

    ffba_datapath #(
        .PAGE_BYTES         (PAGE_BYTES),
        .BLOCK_HEADER_BYTES (BLOCK_HEADER_BYTES),
        .PAGE_HEADER_BYTES  (PAGE_HEADER_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .in_valid        (cmd_ch.valid),
        .in_command      (cmd_ch.command),
        .in_request_size (cmd_ch.request_size),
        .in_block_offset (cmd_ch.block_offset),
        .out_valid       (rsp_ch.valid),
        .out_ready       (rsp_ch.ready),
        .out_data_offset (rsp_ch.data_offset),
        .out_status      (rsp_ch.status),
        .page_size_we    (page_size_we),
        .page_size_wdata (page_size_wdata)
    );

    assign cmd_ch.ready = ctl.take;

endmodule
